// ===== sv/ps_pkg.sv =====
// ps_pkg: shared types, opcodes, status codes and default sizes for the
// postfix stack evaluator. No dependencies.
package ps_pkg;

  localparam int VAL_W             = 48;
  localparam int OP_W              = 5;
  localparam int DEPTH_W           = 5;
  localparam int STATUS_W          = 3;
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [OP_W-1:0] OP_PUSH    = 5'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 5'd1;
  localparam logic [OP_W-1:0] OP_SUB     = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL     = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV     = 5'd4;
  localparam logic [OP_W-1:0] OP_MOD     = 5'd5;
  localparam logic [OP_W-1:0] OP_PUSH_M1 = 5'd6;
  localparam logic [OP_W-1:0] OP_PUSH_P1 = 5'd7;
  localparam logic [OP_W-1:0] OP_SIGN    = 5'd8;
  localparam logic [OP_W-1:0] OP_INC     = 5'd9;
  localparam logic [OP_W-1:0] OP_DEC     = 5'd10;
  localparam logic [OP_W-1:0] OP_LT      = 5'd11;
  localparam logic [OP_W-1:0] OP_GT      = 5'd12;
  localparam logic [OP_W-1:0] OP_LE      = 5'd13;
  localparam logic [OP_W-1:0] OP_GE      = 5'd14;
  localparam logic [OP_W-1:0] OP_EQ      = 5'd15;
  localparam logic [OP_W-1:0] OP_NE      = 5'd16;
  localparam logic [OP_W-1:0] OP_AND     = 5'd17;
  localparam logic [OP_W-1:0] OP_OR      = 5'd18;
  localparam logic [OP_W-1:0] OP_POP     = 5'd19;

  localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] STS_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_SAT   = 3'd4;

  localparam logic signed [VAL_W-1:0] MAX_POS = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] MIN_NEG = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [DEPTH_W-1:0]      depth;
    logic [STATUS_W-1:0]     status;
  } out_t;

  typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_mode_t;

  typedef struct packed {
    logic     start;
    md_mode_t mode;
  } md_req_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [VAL_W-1:0] res;
  } md_rsp_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT} state_t;

endpackage

// ===== sv/postfix_stack_evaluator.sv =====
// postfix_stack_evaluator: top level. Operand stack in ps_ram with the top
// entry cached in a register; ps_muldiv does mul, div and mod. Uses ps_pkg.
//
// Usage: each input transfer carries one opcode and, for a push, a 48-bit
// signed fixed-point operand. Each accepted item yields exactly one output
// transfer: the new stack top (or the popped value for a pop), the depth
// after the step and a status code.
// Timing: the item is accepted in idle and the entry below the top is read
// into the RAM read register in that cycle. The step completes once the
// output register is free: most ops in the execute state; multiply and
// sign-apply (four partial products in the shared multiplier), divide and
// modulo (one quotient bit per cycle) in the wait state, after ps_muldiv.
// One item is in flight at a time. A finished result sits in the output
// register; the next item is accepted while it waits, but that item does
// not complete until the receiver takes the earlier result.
// Reset: the stack count clears to zero; stack contents need no clearing.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH   = ps_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = ps_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ps_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ps_pkg::out_t  out_data
);

  localparam int VW = ps_pkg::VAL_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic signed [VW-1:0] ONE_FX = {{(VW-1){1'b0}}, 1'b1} << FRACTION_BITS;

  ps_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]           count_r, cnt_nxt;
  logic signed [VW-1:0]    top_r, top_nxt;
  logic [ps_pkg::OP_W-1:0] op_r;
  logic signed [VW-1:0]    x_r;
  logic                    out_valid_r;
  ps_pkg::out_t            out_data_r;

  logic                    in_fire, out_free, commit;
  logic                    we, unit_op;
  logic [AW-1:0]           waddr, raddr;
  logic signed [VW-1:0]    rd, a, b, r, pv, outv;
  logic [VW:0]             sum;
  logic [VW-1:0]           bmag;
  logic [ps_pkg::STATUS_W-1:0] status;
  logic                    sat, popped, truth;
  logic                    md_start;
  ps_pkg::md_mode_t        md_mode;
  ps_pkg::md_req_t         md_req;
  ps_pkg::md_rsp_t         md_rsp;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign raddr    = AW'(count_r - CW'(2));
  assign a        = rd;
  assign b        = top_r;
  assign bmag     = b[VW-1] ? VW'(-b) : VW'(b);
  assign md_req   = '{start: md_start, mode: md_mode};

  ps_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk    (clk),
    .we     (we && commit),
    .waddr  (waddr),
    .wdata  (top_nxt),
    .re     (in_fire),
    .raddr  (raddr),
    .rdata_r(rd)
  );

  ps_muldiv #(.FRACTION_BITS(FRACTION_BITS)) u_md (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (md_req),
    .a    (a),
    .b    (b),
    .rsp  (md_rsp)
  );

  // step datapath: evaluates the latched op against the cached top and RAM read
  always_comb begin
    status  = ps_pkg::STS_OK;
    cnt_nxt = count_r;
    top_nxt = top_r;
    we      = 1'b0;
    waddr   = AW'(count_r);
    popped  = 1'b0;
    sat     = 1'b0;
    unit_op = 1'b0;
    truth   = 1'b0;
    r       = '0;
    sum     = '0;
    pv      = (op_r == ps_pkg::OP_PUSH) ? x_r :
              ((op_r == ps_pkg::OP_PUSH_M1) ? -ONE_FX : ONE_FX);
    md_mode = ps_pkg::MD_MUL;
    case (op_r)
      ps_pkg::OP_PUSH, ps_pkg::OP_PUSH_M1, ps_pkg::OP_PUSH_P1: begin
        if (count_r >= CW'(STACK_DEPTH)) begin
          status = ps_pkg::STS_OVER;
        end else begin
          we      = 1'b1;
          top_nxt = pv;
          cnt_nxt = count_r + CW'(1);
        end
      end
      ps_pkg::OP_POP: begin
        if (count_r == '0) begin
          status = ps_pkg::STS_UNDER;
        end else begin
          popped  = 1'b1;
          cnt_nxt = count_r - CW'(1);
          top_nxt = a;
        end
      end
      ps_pkg::OP_INC, ps_pkg::OP_DEC: begin
        if (count_r == '0) begin
          status = ps_pkg::STS_UNDER;
        end else begin
          sum = (op_r == ps_pkg::OP_INC) ? {b[VW-1], b} + {ONE_FX[VW-1], ONE_FX}
                                         : {b[VW-1], b} - {ONE_FX[VW-1], ONE_FX};
          if (sum[VW] != sum[VW-1]) begin
            sat = 1'b1;
            r   = sum[VW] ? ps_pkg::MIN_NEG : ps_pkg::MAX_POS;
          end else begin
            r = $signed(sum[VW-1:0]);
          end
          we      = 1'b1;
          waddr   = AW'(count_r - CW'(1));
          top_nxt = r;
        end
      end
      ps_pkg::OP_ADD, ps_pkg::OP_SUB, ps_pkg::OP_MUL, ps_pkg::OP_DIV,
      ps_pkg::OP_MOD, ps_pkg::OP_SIGN, ps_pkg::OP_LT, ps_pkg::OP_GT,
      ps_pkg::OP_LE, ps_pkg::OP_GE, ps_pkg::OP_EQ, ps_pkg::OP_NE,
      ps_pkg::OP_AND, ps_pkg::OP_OR: begin
        if (count_r < CW'(2)) begin
          status = ps_pkg::STS_UNDER;
        end else begin
          case (op_r)
            ps_pkg::OP_ADD, ps_pkg::OP_SUB: begin
              sum = (op_r == ps_pkg::OP_ADD) ? {a[VW-1], a} + {b[VW-1], b}
                                             : {a[VW-1], a} - {b[VW-1], b};
              if (sum[VW] != sum[VW-1]) begin
                sat = 1'b1;
                r   = sum[VW] ? ps_pkg::MIN_NEG : ps_pkg::MAX_POS;
              end else begin
                r = $signed(sum[VW-1:0]);
              end
            end
            ps_pkg::OP_MUL, ps_pkg::OP_SIGN: begin
              unit_op = 1'b1;
            end
            ps_pkg::OP_DIV: begin
              md_mode = ps_pkg::MD_DIV;
              if (b == '0) status = ps_pkg::STS_DIVZ;
              else         unit_op = 1'b1;
            end
            ps_pkg::OP_MOD: begin
              md_mode = ps_pkg::MD_MOD;
              if ((bmag >> FRACTION_BITS) == '0) status = ps_pkg::STS_DIVZ;
              else                                unit_op = 1'b1;
            end
            ps_pkg::OP_LT:  truth = a < b;
            ps_pkg::OP_GT:  truth = a > b;
            ps_pkg::OP_LE:  truth = a <= b;
            ps_pkg::OP_GE:  truth = a >= b;
            ps_pkg::OP_EQ:  truth = a == b;
            ps_pkg::OP_NE:  truth = a != b;
            ps_pkg::OP_AND: truth = (a == ONE_FX) && (b == ONE_FX);
            default:        truth = (a != '0) || (b != '0);
          endcase
          if (unit_op) begin
            r   = md_rsp.res;
            sat = md_rsp.sat;
          end else if (op_r >= ps_pkg::OP_LT) begin
            r = truth ? ONE_FX : '0;
          end
          if (status != ps_pkg::STS_DIVZ) begin
            we      = 1'b1;
            waddr   = AW'(count_r - CW'(2));
            top_nxt = r;
            cnt_nxt = count_r - CW'(1);
          end
        end
      end
      default: ;
    endcase
    if (status == ps_pkg::STS_OK && sat) status = ps_pkg::STS_SAT;
    outv = popped ? b : ((cnt_nxt != '0) ? top_nxt : '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ps_pkg::S_IDLE: if (in_fire) state_nxt = ps_pkg::S_EXEC;
      ps_pkg::S_EXEC: begin
        if (unit_op)       state_nxt = ps_pkg::S_WAIT;
        else if (out_free) state_nxt = ps_pkg::S_IDLE;
      end
      ps_pkg::S_WAIT: if (md_rsp.done && out_free) state_nxt = ps_pkg::S_IDLE;
      default: state_nxt = ps_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    md_start = 1'b0;
    case (state_r)
      ps_pkg::S_IDLE: in_ready = 1'b1;
      ps_pkg::S_EXEC: begin
        md_start = unit_op;
        commit   = !unit_op && out_free;
      end
      ps_pkg::S_WAIT: commit = md_rsp.done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ps_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_data.op;
      x_r  <= in_data.operand_value;
    end
    if (commit) begin
      top_r             <= top_nxt;
      out_data_r.value  <= outv;
      out_data_r.depth  <= ps_pkg::DEPTH_W'(cnt_nxt);
      out_data_r.status <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ps_ram.sv =====
// ps_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== sv/ps_muldiv.sv =====
// ps_muldiv: iterative fixed-point multiply (four 24x24 partials) and
// restoring divide / integer remainder, one bit per cycle. Uses ps_pkg.
module ps_muldiv #(
  parameter int FRACTION_BITS = ps_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ps_pkg::md_req_t                req,
  input  logic signed [ps_pkg::VAL_W-1:0] a,
  input  logic signed [ps_pkg::VAL_W-1:0] b,
  output ps_pkg::md_rsp_t                rsp
);

  localparam int VW = ps_pkg::VAL_W;
  localparam int HW = VW / 2;
  localparam int DW = VW + FRACTION_BITS;
  localparam int PW = 2 * VW;
  localparam int CW = $clog2(DW + 1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (VW - 1);
  localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

  logic             busy_r, done_r, neg_r, sa_r;
  ps_pkg::md_mode_t mode_r;
  logic [VW-1:0]    ma_r, mb_r, rem_r;
  logic [CW-1:0]    cnt_r;
  logic [VW-1:0]    prod_r;
  logic [5:0]       sh_r;
  logic [PW-1:0]    acc_r;
  logic [DW-1:0]    dvd_r, q_r;

  logic [VW-1:0] ma_in, mb_in;
  logic [HW-1:0] ca, cb;
  logic [5:0]    sh_nxt;
  logic [VW:0]   rem_s, rem_d;
  logic          qbit;
  logic [PW-1:0] mag;
  logic          big;
  logic [VW-1:0] mod_mag;

  assign ma_in = a[VW-1] ? VW'(-a) : VW'(a);
  assign mb_in = b[VW-1] ? VW'(-b) : VW'(b);

  assign ca     = cnt_r[0] ? ma_r[VW-1:HW] : ma_r[HW-1:0];
  assign cb     = cnt_r[1] ? mb_r[VW-1:HW] : mb_r[HW-1:0];
  assign sh_nxt = (cnt_r[0] & cnt_r[1]) ? 6'(2 * HW) :
                  ((cnt_r[0] | cnt_r[1]) ? 6'(HW) : 6'd0);

  assign rem_s = {rem_r, dvd_r[DW-1]};
  assign qbit  = rem_s >= {1'b0, mb_r};
  assign rem_d = qbit ? rem_s - {1'b0, mb_r} : rem_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if ((mode_r == ps_pkg::MD_MUL && cnt_r == CW'(4)) ||
          (mode_r != ps_pkg::MD_MUL && cnt_r == CW'(DW - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      sa_r   <= a[VW-1];
      neg_r  <= (req.mode == ps_pkg::MD_MOD) ? a[VW-1] : (a[VW-1] ^ b[VW-1]);
      ma_r   <= ma_in;
      mb_r   <= (req.mode == ps_pkg::MD_MOD) ? (mb_in >> FRACTION_BITS) : mb_in;
      dvd_r  <= (req.mode == ps_pkg::MD_MOD) ? DW'(ma_in >> FRACTION_BITS)
                                             : (DW'(ma_in) << FRACTION_BITS);
      cnt_r  <= '0;
      acc_r  <= '0;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (mode_r == ps_pkg::MD_MUL) begin
        if (cnt_r < CW'(4)) begin
          prod_r <= ca * cb;
          sh_r   <= sh_nxt;
        end
        if (cnt_r != '0) begin
          acc_r <= acc_r + (PW'(prod_r) << sh_r);
        end
      end else begin
        rem_r <= rem_d[VW-1:0];
        q_r   <= {q_r[DW-2:0], qbit};
        dvd_r <= dvd_r << 1;
      end
    end
  end

  always_comb begin
    mag     = (mode_r == ps_pkg::MD_MUL) ? (acc_r >> FRACTION_BITS) : PW'(q_r);
    big     = (mode_r == ps_pkg::MD_DIV) && ((q_r >> VW) != '0);
    mod_mag = rem_r << FRACTION_BITS;
    rsp.done = done_r;
    rsp.sat  = 1'b0;
    rsp.res  = '0;
    if (mode_r == ps_pkg::MD_MOD) begin
      rsp.res = sa_r ? -$signed(mod_mag) : $signed(mod_mag);
    end else if (neg_r) begin
      if (big || mag > LIM_NEG) begin
        rsp.sat = 1'b1;
        rsp.res = ps_pkg::MIN_NEG;
      end else begin
        rsp.res = -$signed(mag[VW-1:0]);
      end
    end else begin
      if (big || mag > LIM_POS) begin
        rsp.sat = 1'b1;
        rsp.res = ps_pkg::MAX_POS;
      end else begin
        rsp.res = $signed(mag[VW-1:0]);
      end
    end
  end

endmodule

// ===== sv/ps_chk.sv =====
// ps_chk: port-level checks for postfix_stack_evaluator, bound to the top.
// Uses ps_pkg.
module ps_chk #(
  parameter int STACK_DEPTH = ps_pkg::STACK_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input ps_pkg::out_t out_data
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.depth <= ps_pkg::DEPTH_W'(STACK_DEPTH))
    else $error("depth above stack size");

  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ps_pkg::STS_OVER
      |-> out_data.depth == ps_pkg::DEPTH_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item in flight: no input transfer on the cycle after one
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind postfix_stack_evaluator ps_chk #(.STACK_DEPTH(STACK_DEPTH)) u_ps_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
